FILE: rtl/core/next_permutation_multiset_macros.svh
// Assertion macros for the next_permutation_multiset block.
// Used by the top level; expects signals aclk and aresetn in scope.
`ifndef NEXT_PERMUTATION_MULTISET_MACROS_SVH
`define NEXT_PERMUTATION_MULTISET_MACROS_SVH

// same-cycle implication
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/nps_pkg.sv
// Package for the next_permutation_multiset block: sizes, element type,
// cell control struct and sequencer states. No dependencies.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_ELEMS = 8;
    localparam int SHOWN     = 8;
    localparam int ELEM_W    = 16;
    localparam int CNT_W     = 4;
    localparam int IDX_W     = $clog2(MAX_ELEMS);
    localparam int SUM_W     = CNT_W + 1;

    typedef logic signed [ELEM_W-1:0] elem_t;

    typedef struct packed {
        logic  ins_en;
        logic  perm_en;
        elem_t ins_value;
    } nps_cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWAP
    } nps_state_t;

endpackage

FILE: rtl/core/nps_cell.sv
// One storage cell of the element chain: sorted-insert shift from the left
// neighbor, permutation write, and compares. Depends on nps_pkg.
`timescale 1ns / 1ps

module nps_cell
    import nps_pkg::*;
(
    input  logic          aclk,
    input  nps_cell_ctl_t ctl,
    input  logic          in_range,
    input  logic          is_tail,
    input  elem_t         left_elem,
    input  logic          left_gt,
    input  elem_t         right_elem,
    input  elem_t         perm_value,
    output elem_t         elem,
    output logic          gt,
    output logic          lt_right
);

    elem_t elem_reg;
    elem_t elem_next;

    assign elem     = elem_reg;
    assign gt       = elem_reg > ctl.ins_value;
    assign lt_right = elem_reg < right_elem;

    always_comb begin
        elem_next = elem_reg;
        if (ctl.ins_en && in_range) begin
            if (left_gt) begin
                elem_next = left_elem;
            end else if (gt || is_tail) begin
                elem_next = ctl.ins_value;
            end
        end else if (ctl.perm_en) begin
            elem_next = perm_value;
        end
    end

    always_ff @(posedge aclk) begin
        elem_reg <= elem_next;
    end

endmodule

FILE: rtl/core/next_permutation_multiset.sv
// Top level of the next_permutation_multiset block: control, pivot search,
// swap/reverse select and output register. Depends on nps_pkg, nps_cell
// and next_permutation_multiset_macros.svh.
`timescale 1ns / 1ps
`include "next_permutation_multiset_macros.svh"

// A load item (cmd 0) inserts its value into the sorted chain of cells in
// the cycle it is accepted, so loads go at one per cycle while no next item
// is in its write-back step; loads past MAX_ELEMS are dropped, and a load
// after a closed set starts a new set. For a next item (cmd 1), in the
// accept cycle the current arrangement, count and final flag are registered
// and the pivot is found by neighbor compares; in the following cycle the
// rightmost larger cell is found and the swap and suffix reversal are
// written back into all cells. No new item is taken until that write-back
// is done. A next item is not taken while an undelivered result sits in
// the output register; loads are taken regardless.
module next_permutation_multiset
    import nps_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_cmd,
    input  logic signed [15:0] s_value,
    input  logic               s_last_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_elem_0,
    output logic signed [15:0] m_elem_1,
    output logic signed [15:0] m_elem_2,
    output logic signed [15:0] m_elem_3,
    output logic signed [15:0] m_elem_4,
    output logic signed [15:0] m_elem_5,
    output logic signed [15:0] m_elem_6,
    output logic signed [15:0] m_elem_7,
    output logic [3:0]         m_used_count,
    output logic               m_final_arrangement
);

    nps_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             closed_reg, closed_next;
    logic             m_valid_reg;

    logic [IDX_W-1:0] p_reg;
    logic             have_p_reg;
    elem_t            pv_reg;

    elem_t            out_elem_reg [SHOWN];
    logic [CNT_W-1:0] out_count_reg;
    logic             out_final_reg;

    elem_t            elem       [MAX_ELEMS];
    logic             gt         [MAX_ELEMS];
    logic             lt_right   [MAX_ELEMS];
    elem_t            perm_value [MAX_ELEMS];
    elem_t            sw         [MAX_ELEMS];
    elem_t            shown      [SHOWN];

    logic             s_fire, load_fire, next_fire, ins_ok;
    logic [CNT_W-1:0] cnt_eff;
    logic             have_p;
    logic [IDX_W-1:0] p_idx, j_idx;
    logic [SUM_W-1:0] start, sum;
    nps_cell_ctl_t    ctl;

    assign s_ready   = (state_reg == ST_IDLE) && (!s_cmd || !m_valid_reg || m_ready);
    assign s_fire    = s_valid && s_ready;
    assign load_fire = s_fire && !s_cmd;
    assign next_fire = s_fire && s_cmd;
    assign cnt_eff   = closed_reg ? '0 : count_reg;
    assign ins_ok    = cnt_eff < CNT_W'(MAX_ELEMS);

    assign ctl.ins_en    = load_fire && ins_ok;
    assign ctl.perm_en   = (state_reg == ST_SWAP);
    assign ctl.ins_value = s_value;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMS; g++) begin : g_cell
            nps_cell u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .in_range   (CNT_W'(g) <= cnt_eff),
                .is_tail    (CNT_W'(g) == cnt_eff),
                .left_elem  ((g == 0) ? elem_t'(0) : elem[(g == 0) ? 0 : g - 1]),
                .left_gt    ((g == 0) ? 1'b0 : gt[(g == 0) ? 0 : g - 1]),
                .right_elem ((g == MAX_ELEMS - 1) ? elem_t'(0)
                                                  : elem[(g == MAX_ELEMS - 1) ? g : g + 1]),
                .perm_value (perm_value[g]),
                .elem       (elem[g]),
                .gt         (gt[g]),
                .lt_right   (lt_right[g])
            );
        end
        for (g = 0; g < SHOWN; g++) begin : g_shown
            if (g < MAX_ELEMS) begin : g_on
                assign shown[g] = elem[g];
            end else begin : g_off
                assign shown[g] = '0;
            end
        end
    endgenerate

    // pivot: rightmost strict ascent inside the used range
    always_comb begin
        have_p = 1'b0;
        p_idx  = '0;
        for (int k = 0; k < MAX_ELEMS - 1; k++) begin
            if (lt_right[k] && (CNT_W'(k + 1) < count_reg)) begin
                have_p = 1'b1;
                p_idx  = IDX_W'(k);
            end
        end
    end

    // swap partner, then swap and reverse the suffix
    always_comb begin
        j_idx = p_reg;
        for (int k = 0; k < MAX_ELEMS; k++) begin
            if ((elem[k] > pv_reg) && (IDX_W'(k) > p_reg) && (CNT_W'(k) < count_reg)) begin
                j_idx = IDX_W'(k);
            end
        end
        for (int k = 0; k < MAX_ELEMS; k++) begin
            if (have_p_reg && (IDX_W'(k) == p_reg)) begin
                sw[k] = elem[j_idx];
            end else if (have_p_reg && (IDX_W'(k) == j_idx)) begin
                sw[k] = pv_reg;
            end else begin
                sw[k] = elem[k];
            end
        end
        start = have_p_reg ? (SUM_W'(p_reg) + SUM_W'(1)) : '0;
        sum   = SUM_W'(count_reg) + start - SUM_W'(1);
        for (int k = 0; k < MAX_ELEMS; k++) begin
            if ((SUM_W'(k) >= start) && (CNT_W'(k) < count_reg)) begin
                perm_value[k] = sw[IDX_W'(sum - SUM_W'(k))];
            end else begin
                perm_value[k] = sw[k];
            end
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        closed_next = closed_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load_fire) begin
                    count_next  = ins_ok ? (cnt_eff + CNT_W'(1)) : cnt_eff;
                    closed_next = s_last_value;
                end else if (next_fire) begin
                    closed_next = 1'b1;
                    state_next  = ST_SWAP;
                end
            end
            ST_SWAP: begin
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            closed_reg  <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            closed_reg <= closed_next;
            if (next_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (next_fire) begin
            for (int k = 0; k < SHOWN; k++) begin
                out_elem_reg[k] <= (CNT_W'(k) < count_reg) ? shown[k] : elem_t'(0);
            end
            out_count_reg <= count_reg;
            out_final_reg <= !have_p;
            p_reg         <= p_idx;
            have_p_reg    <= have_p;
            pv_reg        <= elem[p_idx];
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_elem_0            = out_elem_reg[0];
    assign m_elem_1            = out_elem_reg[1];
    assign m_elem_2            = out_elem_reg[2];
    assign m_elem_3            = out_elem_reg[3];
    assign m_elem_4            = out_elem_reg[4];
    assign m_elem_5            = out_elem_reg[5];
    assign m_elem_6            = out_elem_reg[6];
    assign m_elem_7            = out_elem_reg[7];
    assign m_used_count        = out_count_reg;
    assign m_final_arrangement = out_final_reg;

    `NPS_ASSERT_NOW(a_count_cap, 1'b1, count_reg <= CNT_W'(MAX_ELEMS), "count above capacity")
    `NPS_ASSERT_NEXT(a_next_swap, next_fire, state_reg == ST_SWAP && m_valid_reg, "no write-back")
    `NPS_ASSERT_NEXT(a_swap_once, state_reg == ST_SWAP, state_reg == ST_IDLE, "long write-back")
    `NPS_ASSERT_NOW(a_swap_busy, state_reg == ST_SWAP, !s_ready && closed_reg, "busy but ready")

endmodule
